// ===== src/pcg32_bounded_random_generator_top_assert.svh =====
// Assertion macros shared by the generator's port checker
`ifndef PCG32_BOUNDED_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define PCG32_BOUNDED_RANDOM_GENERATOR_TOP_ASSERT_SVH

// Consequent checked at the same edge as the antecedent
`define PCG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the edge after the antecedent
`define PCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcg32_brg_pkg.sv =====
// Types, constants and output mixing function of the PCG32 bounded generator
package pcg32_brg_pkg;

  // LCG multiplier and XSH-RR mixing constants
  localparam logic [63:0] PCG_MULT  = 64'h5851_F42D_4C95_7F2D;
  localparam int unsigned XSH_SHIFT = 18;
  localparam int unsigned XSH_DROP  = 27;
  localparam int unsigned ROT_POS   = 59;

  // Function code of an input word
  localparam logic FUNC_SEED = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEED_GO1,
    S_SEED_WAIT1,
    S_SEED_ADD,
    S_SEED_GO2,
    S_SEED_WAIT2,
    S_FULL_WAIT,
    S_THR_WAIT,
    S_DRAW_GO,
    S_DRAW_WAIT,
    S_TEST,
    S_MOD_WAIT,
    S_MOD_RES,
    S_PUT
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_LOW,
    RES_RAW,
    RES_MOD
  } res_sel_t;

  typedef enum logic {
    DIV_THRESH,
    DIV_SAMPLE
  } div_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     capture;
    logic     seed_init;
    logic     add_start;
    logic     adv_go;
    logic     div_go;
    div_sel_t div_sel;
    logic     thr_load;
    logic     res_load;
    res_sel_t res_sel;
    logic     val_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_seed;
    logic empty;
    logic single;
    logic full_span;
    logic adv_done;
    logic div_done;
    logic below_thr;
  } stat_t;

  // XSH-RR output of a state: xorshift high, rotate by the top five bits
  function automatic logic [31:0] xsh_rr(input logic [63:0] old);
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] twice;
    mixed = 32'(((old >> XSH_SHIFT) ^ old) >> XSH_DROP);
    rot   = old[63:ROT_POS];
    twice = {mixed, mixed} >> rot;
    return twice[31:0];
  endfunction

endpackage

// ===== src/pcg32_brg_ctrl.sv =====
// Controller state machine of the PCG32 bounded generator
module pcg32_brg_ctrl import pcg32_brg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // Hold state and the output word flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.val_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_seed) begin
          cmd.seed_init = 1'b1;
          state_next    = S_SEED_GO1;
        end else if (stat.empty) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_next   = S_PUT;
        end else if (stat.single) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_LOW;
          state_next   = S_PUT;
        end else if (stat.full_span) begin
          cmd.adv_go = 1'b1;
          state_next = S_FULL_WAIT;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_THRESH;
          state_next  = S_THR_WAIT;
        end
      end
      S_SEED_GO1: begin
        cmd.adv_go = 1'b1;
        state_next = S_SEED_WAIT1;
      end
      S_SEED_WAIT1: begin
        if (stat.adv_done) begin
          state_next = S_SEED_ADD;
        end
      end
      S_SEED_ADD: begin
        cmd.add_start = 1'b1;
        state_next    = S_SEED_GO2;
      end
      S_SEED_GO2: begin
        cmd.adv_go = 1'b1;
        state_next = S_SEED_WAIT2;
      end
      S_SEED_WAIT2: begin
        if (stat.adv_done) begin
          state_next = S_IDLE;
        end
      end
      S_FULL_WAIT: begin
        if (stat.adv_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RAW;
          state_next   = S_PUT;
        end
      end
      S_THR_WAIT: begin
        if (stat.div_done) begin
          state_next = S_DRAW_GO;
        end
      end
      S_DRAW_GO: begin
        cmd.thr_load = 1'b1;
        cmd.adv_go   = 1'b1;
        state_next   = S_DRAW_WAIT;
      end
      S_DRAW_WAIT: begin
        if (stat.adv_done) begin
          state_next = S_TEST;
        end
      end
      // Reject a biased sample and draw again, else reduce it
      S_TEST: begin
        if (stat.below_thr) begin
          cmd.adv_go = 1'b1;
          state_next = S_DRAW_WAIT;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_SAMPLE;
          state_next  = S_MOD_WAIT;
        end
      end
      S_MOD_WAIT: begin
        if (stat.div_done) begin
          state_next = S_MOD_RES;
        end
      end
      S_MOD_RES: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_MOD;
        state_next   = S_PUT;
      end
      // Move the result into the output register once it is free
      S_PUT: begin
        if (!out_valid || out_ready) begin
          cmd.val_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/pcg32_brg_dp.sv =====
// Datapath of the PCG32 bounded generator: LCG state, shared multiplier, divider
module pcg32_brg_dp import pcg32_brg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        func,
  input  logic [63:0] start_state,
  input  logic [63:0] stream_id,
  input  logic [31:0] range_low,
  input  logic [31:0] range_high,
  output logic [31:0] value
);

  logic        item_func;
  logic [63:0] item_start;
  logic [63:0] item_stream;
  logic [31:0] item_low;
  logic [31:0] item_high;

  logic [63:0] lcg_state;
  logic [63:0] increment;
  logic [31:0] sample;
  logic [31:0] thr;
  logic [31:0] res;

  logic        adv_busy;
  logic [1:0]  adv_step;
  logic [1:0]  mul_sel;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_p;
  logic [63:0] mul_q;
  logic [63:0] acc;

  logic        div_busy;
  logic [4:0]  div_cnt;
  logic [31:0] div_num;
  logic [31:0] div_rem;
  logic [32:0] rem_sh;
  logic        rem_fits;

  logic [31:0] bound;

  assign bound = item_high - item_low + 32'd1;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_func   <= func;
      item_start  <= start_state;
      item_stream <= stream_id;
      item_low    <= range_low;
      item_high   <= range_high;
    end
  end

  // Pick multiplier operands: low*low, low*high, high*low of state and multiplier
  assign mul_sel = cmd.adv_go ? 2'd0 : adv_step;
  always_comb begin
    case (mul_sel)
      2'd0: begin
        op_a = lcg_state[31:0];
        op_b = PCG_MULT[31:0];
      end
      2'd1: begin
        op_a = lcg_state[31:0];
        op_b = PCG_MULT[63:32];
      end
      default: begin
        op_a = lcg_state[63:32];
        op_b = PCG_MULT[31:0];
      end
    endcase
  end
  assign mul_p = op_a * op_b;

  // Advance the LCG from three partial products and keep the mixed output of the old state
  always_ff @(posedge clk) begin
    mul_q <= mul_p;
    if (rst) begin
      lcg_state <= 64'd0;
      increment <= 64'd1;
      adv_busy  <= 1'b0;
      adv_step  <= 2'd0;
    end else begin
      if (cmd.seed_init) begin
        lcg_state <= 64'd0;
        increment <= {item_stream[62:0], 1'b1};
      end
      if (cmd.add_start) begin
        lcg_state <= lcg_state + item_start;
      end
      if (cmd.adv_go) begin
        sample   <= xsh_rr(lcg_state);
        adv_busy <= 1'b1;
        adv_step <= 2'd1;
      end else if (adv_busy) begin
        adv_step <= adv_step + 2'd1;
        case (adv_step)
          2'd1: acc <= mul_q + increment;
          2'd2: acc <= acc + {mul_q[31:0], 32'd0};
          default: begin
            lcg_state <= acc + {mul_q[31:0], 32'd0};
            adv_busy  <= 1'b0;
          end
        endcase
      end
    end
  end

  // Restoring remainder, one bit a cycle
  assign rem_sh   = {div_rem, div_num[31]};
  assign rem_fits = (rem_sh >= {1'b0, bound});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= 5'd0;
    end else if (cmd.div_go) begin
      div_num  <= (cmd.div_sel == DIV_THRESH) ? (32'd0 - bound) : sample;
      div_rem  <= 32'd0;
      div_cnt  <= 5'd0;
      div_busy <= 1'b1;
    end else if (div_busy) begin
      div_rem  <= rem_fits ? 32'(rem_sh - {1'b0, bound}) : rem_sh[31:0];
      div_num  <= {div_num[30:0], 1'b0};
      div_cnt  <= div_cnt + 5'd1;
      if (div_cnt == 5'd31) begin
        div_busy <= 1'b0;
      end
    end
  end

  // Latch threshold, result and output word
  always_ff @(posedge clk) begin
    if (cmd.thr_load) begin
      thr <= div_rem;
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ZERO: res <= 32'd0;
        RES_LOW:  res <= item_low;
        RES_RAW:  res <= sample;
        RES_MOD:  res <= item_low + div_rem;
        default:  res <= 32'd0;
      endcase
    end
    if (cmd.val_load) begin
      value <= res;
    end
  end

  // Status to the controller
  assign stat.is_seed   = (item_func == FUNC_SEED);
  assign stat.empty     = (item_high < item_low);
  assign stat.single    = (item_high == item_low);
  assign stat.full_span = (bound == 32'd0);
  assign stat.adv_done  = adv_busy && (adv_step == 2'd3);
  assign stat.div_done  = div_busy && (div_cnt == 5'd31);
  assign stat.below_thr = (sample < thr);

endmodule

// ===== src/pcg32_bounded_random_generator_top.sv =====
// Top level of the PCG32 XSH-RR generator with unbiased bounded draws
//
//   Channel | Direction | Handshake            | Payload
//   in      | input     | in_valid / in_ready  | func, start_state, stream_id,
//           |           |                      | range_low, range_high
//   out     | output    | out_valid / out_ready| value
//
// One word is worked on at a time; in_ready is high only while the controller idles.
// Seed word: two LCG advances, both on the one 32x32 multiplier, before the next acceptance.
// Draw word: one advance and two remainder passes (threshold and reduction), plus one
// advance per rejected sample; empty or single-value ranges need none, full span just one.
// Reset sets the state to 0 and the increment to 1. A stalled output word holds the
// next result in the datapath, and the controller, until the register is free.
module pcg32_bounded_random_generator_top import pcg32_brg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [63:0] start_state,
  input  logic [63:0] stream_id,
  input  logic [31:0] range_low,
  input  logic [31:0] range_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence the work
  pcg32_brg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold state and compute
  pcg32_brg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .start_state (start_state),
    .stream_id   (stream_id),
    .range_low   (range_low),
    .range_high  (range_high),
    .value       (value)
  );

endmodule

// ===== src/pcg32_brg_chk.sv =====
// Port checker of the PCG32 bounded generator and its bind to the top level
`include "pcg32_bounded_random_generator_top_assert.svh"

module pcg32_brg_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value
);

  // A waiting output word holds
  `PCG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value), "output word changed while stalled")

  // Busy straight after taking a word
  `PCG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "took a second word back to back")

  // A new result is only loaded while the block is busy
  `PCG_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result appeared from idle")

  // No result straight out of reset
  `PCG_ASSERT_SAME(a_reset_quiet, $past(rst), !out_valid, "output valid right after reset")

endmodule

bind pcg32_bounded_random_generator_top pcg32_brg_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value)
);
